// File: rtl/smp_pkg.sv
// Shared types and constants for the spectrum magnitude and peak block.
// No dependencies; every other file in rtl/ imports this package.
package smp_pkg;

	localparam int NUM_POINTS_DEF = 256;

	localparam int IN_W    = 16;
	localparam int RAD_W   = 34;            // 4*(re^2+im^2) fits below 2^34
	localparam int ROOT_W  = RAD_W / 2;     // one root bit per radicand bit pair
	localparam int REM_W   = ROOT_W + 3;
	localparam int SQ_STEPS = ROOT_W;

	localparam int MAG_W    = 17;
	localparam int LEVEL_W  = 8;
	localparam int PEAK_W   = 7;
	localparam int ZOOM_W   = 2;
	localparam logic [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(1);

	// floor(mag/25) as (mag * ceil(2^22/25)) >> 22, exact for mag < 2^17
	localparam int LVL_DIV   = 25;
	localparam int LVL_SHIFT = 22;
	localparam int RECIP_W   = 18;
	localparam logic [RECIP_W-1:0] LVL_RECIP =
		RECIP_W'(((2 ** LVL_SHIFT) + LVL_DIV - 1) / LVL_DIV);
	localparam int PROD_W   = MAG_W + RECIP_W;
	localparam int QUO_W    = PROD_W - LVL_SHIFT;
	localparam int SCL_W    = QUO_W + ZOOM_W;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255);

	typedef struct packed {
		logic signed [IN_W-1:0] bin_real;
		logic signed [IN_W-1:0] bin_imag;
	} smp_in_t;

	typedef struct packed {
		logic [MAG_W-1:0]   magnitude;
		logic [LEVEL_W-1:0] display_level;
		logic [PEAK_W-1:0]  peak_index;
		logic               frame_end;
	} smp_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PWR_RE,
		ST_PWR_IM,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_LVL_WAIT,
		ST_WRITE
	} smp_state_t;

	// sequencer strobes to the arithmetic units, the output register and the input
	typedef struct packed {
		logic sq_start;
		logic lvl_start;
		logic load_out;
		logic in_ready;
	} smp_ctl_t;

endpackage

// File: rtl/smp_isqrt.sv
// Iterative integer square root, one root bit per cycle (restoring method).
// Depends on smp_pkg for the radicand and root widths.
module smp_isqrt
	import smp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(SQ_STEPS);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;
	logic              last_step;

	// remainder stays below 2^(ROOT_W+1), so its top two bits can be shifted out
	assign rem_sh    = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign fits      = rem_sh >= trial;
	assign last_step = cnt_q == CNT_W'(SQ_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_step)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/smp_level.sv
// Display level: floor(magnitude/25) * zoom, saturated, over two stages.
// Depends on smp_pkg for the reciprocal constant and widths.
module smp_level
	import smp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MAG_W-1:0]   mag,
	input  logic [ZOOM_W-1:0]  zoom,
	output logic               done,
	output logic [LEVEL_W-1:0] level
);

	logic [PROD_W-1:0]  prod_s1;
	logic               v_s1;
	logic [LEVEL_W-1:0] level_s2;
	logic               v_s2;

	logic [QUO_W-1:0]   quo;
	logic [SCL_W-1:0]   scaled;

	assign quo    = prod_s1[PROD_W-1:LVL_SHIFT];
	assign scaled = SCL_W'(quo) * SCL_W'(zoom);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			prod_s1 <= PROD_W'(mag) * PROD_W'(LVL_RECIP);
		if (v_s1)
			level_s2 <= (scaled > SCL_W'(LEVEL_MAX)) ? LEVEL_MAX : scaled[LEVEL_W-1:0];
	end

	assign done  = v_s2;
	assign level = level_s2;

endmodule

// File: rtl/spectrum_magnitude_peak.sv
// Spectrum magnitude and peak detector: top level with sequencer and frame tracking.
// Depends on smp_pkg, smp_isqrt and smp_level.

// Bins of one frame (NUM_POINTS/2 of them) arrive in order, one transaction per bin.
// Bin 0 gives floor(sqrt(re^2+im^2)), every other bin the doubled magnitude
// floor(sqrt(4*(re^2+im^2))); each result also carries floor(magnitude/25)*zoom
// saturated to 255, and on the frame's last bin the index (low 7 bits) of the
// first bin with the largest magnitude. From acceptance until in_ready returns a
// bin passes through squaring of re and then im on one shared multiplier, a state
// that starts the root, the 17-step bit-serial square root and its registered done
// flag, the level pipeline and the load of the output register; only then can the
// next bin be accepted, so one bin is in flight at a time. The output register holds
// a result while the next bin is worked on; the block waits before loading only if
// that result is still untaken. zoom (cfg_wdata) resets to 1; the user must see that it is
// written only while no bin is in flight, since the block itself does not enforce this.
module spectrum_magnitude_peak
	import smp_pkg::*;
#(
	parameter int NUM_POINTS = NUM_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [ZOOM_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  smp_in_t           in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output smp_out_t          out_data
);

	localparam int BINS  = NUM_POINTS / 2;
	localparam int POS_W = (BINS > 1) ? $clog2(BINS) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BINS - 1);

	smp_state_t state_q, state_d;
	smp_ctl_t   ctl;

	logic [ZOOM_W-1:0]      zoom_q;
	logic signed [IN_W-1:0] re_q;
	logic signed [IN_W-1:0] im_q;
	logic [31:0]            pwr_q;
	logic [POS_W-1:0]       pos_q;
	logic [MAG_W-1:0]       best_mag_q;
	logic [POS_W-1:0]       best_pos_q;
	logic                   out_valid_q;
	smp_out_t               out_q;

	logic signed [IN_W-1:0] mul_op;
	logic signed [31:0]     sq_prod;
	logic [RAD_W-1:0]       radicand;
	logic                   sq_done;
	logic [ROOT_W-1:0]      root;
	logic                   lvl_done;
	logic [LEVEL_W-1:0]     level;
	logic                   out_free;
	logic                   bigger;
	logic [POS_W-1:0]       peak_pos;
	logic                   frame_end;

	// one multiplier shared by both squares
	assign mul_op   = (state_q == ST_PWR_RE) ? re_q : im_q;
	assign sq_prod  = mul_op * mul_op;
	assign radicand = (pos_q == '0) ? {2'b00, pwr_q} : {pwr_q, 2'b00};

	smp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (root)
	);

	smp_level u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.lvl_start),
		.mag    (root),
		.zoom   (zoom_q),
		.done   (lvl_done),
		.level  (level)
	);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_PWR_RE;
			ST_PWR_RE:    state_d = ST_PWR_IM;
			ST_PWR_IM:    state_d = ST_ROOT_GO;
			ST_ROOT_GO:   state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: if (sq_done) state_d = ST_LVL_WAIT;
			ST_LVL_WAIT:  if (lvl_done) state_d = ST_WRITE;
			ST_WRITE:     if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.in_ready  = state_q == ST_IDLE;
		ctl.sq_start  = state_q == ST_ROOT_GO;
		ctl.lvl_start = (state_q == ST_ROOT_WAIT) && sq_done;
		ctl.load_out  = (state_q == ST_WRITE) && out_free;
	end

	// strictly greater replaces, so ties keep the earlier bin
	assign bigger    = root > best_mag_q;
	assign peak_pos  = bigger ? pos_q : best_pos_q;
	assign frame_end = pos_q >= LAST_POS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zoom_q      <= ZOOM_RESET;
			pos_q       <= '0;
			best_mag_q  <= '0;
			best_pos_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen)
				zoom_q <= cfg_wdata;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
				if (frame_end) begin
					pos_q      <= '0;
					best_mag_q <= '0;
					best_pos_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					if (bigger) begin
						best_mag_q <= root;
						best_pos_q <= pos_q;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.in_ready && in_valid) begin
			re_q <= in_data.bin_real;
			im_q <= in_data.bin_imag;
		end
		if (state_q == ST_PWR_RE)
			pwr_q <= unsigned'(sq_prod);
		else if (state_q == ST_PWR_IM)
			pwr_q <= pwr_q + unsigned'(sq_prod);
		if (ctl.load_out) begin
			out_q.magnitude     <= root;
			out_q.display_level <= level;
			out_q.peak_index    <= frame_end ? PEAK_W'(peak_pos) : '0;
			out_q.frame_end     <= frame_end;
		end
	end

	assign in_ready  = ctl.in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// one bin in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a bin is in flight");

	a_peak_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.frame_end) |-> (out_data.peak_index == '0))
		else $error("peak index set outside the frame's last bin");

	a_root_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_ROOT_WAIT))
		else $error("square root finished outside its wait state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !ctl.load_out)
		else $error("output register reloaded before its transaction");

endmodule
